@@ src/mssu_pkg.sv @@
// ----------------------------------------------------------------------------
// mssu_pkg: shared types and constants of the merge sorter
// key and handle port widths, key order and the merge control bundle
// ----------------------------------------------------------------------------
package mssu_pkg;

  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned HANDLE_PORT = 16;

  // control bundle from the merge sequencer to the datapath
  typedef struct packed {
    logic wr_en;     // write one merged entry into the destination bank
    logic src_bank;  // bank being read in this pass
    logic take_b;    // entry comes from the right run
    logic done;      // sort finished this cycle
    logic fin_bank;  // bank holding the sorted batch
  } mrg_ctl_t;

  // signed less-than on raw keys
  function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

@@ src/mssu_mem.sv @@
// ----------------------------------------------------------------------------
// mssu_mem: entry bank
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module mssu_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ src/mssu_merge.sv @@
// ----------------------------------------------------------------------------
// mssu_merge: bottom-up merge sequencer
// walks run pairs pass by pass with one shared key comparator, ping-pong banks
// ----------------------------------------------------------------------------
module mssu_merge #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     n_i,
  input  logic [mssu_pkg::KEY_BITS-1:0]        key_a_i,
  input  logic [mssu_pkg::KEY_BITS-1:0]        key_b_i,
  output logic [$clog2(MAX_ENTRIES)-1:0]       raddr_a_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       raddr_b_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       waddr_o,
  output mssu_pkg::mrg_ctl_t                   ctl_o
);

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW   = AW + 2;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_READ = 3'b010,
    M_STEP = 3'b100
  } mrg_state_e;

  mrg_state_e state_q, state_d;
  logic [CNTW-1:0] n_q, n_d;
  logic [CW-1:0] w_q, w_d, i_q, i_d, j_q, j_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
  logic src_q, src_d;

  logic [CW-1:0] n_ext, run_lo, run_w, sum_mid, sum_hi, mid_c, hi_c;
  logic [CW-1:0] k_inc, w_dbl;
  logic take_b, run_end, pass_end, setup;

  assign n_ext   = (state_q == M_IDLE) ? CW'(n_i) : CW'(n_q);
  assign sum_mid = run_lo + run_w;
  assign sum_hi  = sum_mid + run_w;
  assign mid_c   = (sum_mid < n_ext) ? sum_mid : n_ext;
  assign hi_c    = (sum_hi < n_ext) ? sum_hi : n_ext;

  // left run wins unless its key is strictly less
  assign take_b = (i_q >= mid_q) ||
                  ((j_q < hi_q) && mssu_pkg::key_less(key_a_i, key_b_i));
  assign k_inc    = k_q + CW'(1);
  assign w_dbl    = w_q << 1;
  assign run_end  = (k_inc == hi_q);
  assign pass_end = run_end && (hi_q >= n_ext);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    w_d     = w_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    src_d   = src_q;
    run_lo  = hi_q;
    run_w   = w_q;
    setup   = 1'b0;
    ctl_o   = '0;
    ctl_o.src_bank = src_q;
    ctl_o.take_b   = take_b;
    case (state_q)
      M_IDLE: begin
        run_lo = '0;
        run_w  = CW'(1);
        if (start_i) begin
          n_d   = n_i;
          w_d   = CW'(1);
          src_d = 1'b0;
          if (n_ext <= CW'(1)) begin
            ctl_o.done     = 1'b1;
            ctl_o.fin_bank = 1'b0;
          end else begin
            setup   = 1'b1;
            state_d = M_READ;
          end
        end
      end
      M_READ: begin
        state_d = M_STEP;
      end
      M_STEP: begin
        ctl_o.wr_en = 1'b1;
        k_d = k_inc;
        if (take_b) begin
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + CW'(1);
        end
        state_d = M_READ;
        if (pass_end) begin
          src_d  = ~src_q;
          w_d    = w_dbl;
          run_lo = '0;
          run_w  = w_dbl;
          if (w_dbl >= n_ext) begin
            ctl_o.done     = 1'b1;
            ctl_o.fin_bank = ~src_q;
            state_d        = M_IDLE;
          end else begin
            setup = 1'b1;
          end
        end else if (run_end) begin
          setup = 1'b1;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
    if (setup) begin
      i_d   = run_lo;
      j_d   = mid_c;
      k_d   = run_lo;
      mid_d = mid_c;
      hi_d  = hi_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
  end

  assign raddr_a_o = i_q[AW-1:0];
  assign raddr_b_o = j_q[AW-1:0];
  assign waddr_o   = k_q[AW-1:0];

endmodule

@@ src/stable_descending_merge_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// stable_descending_merge_sorter_unit: stable descending merge sorter
// loads a batch, merge-sorts it by descending signed key, emits it in order
// ----------------------------------------------------------------------------
// words are accepted while in_ready_o is high; each entry of a merge pass then goes
//   through M_READ and M_STEP, over ceil(log2 n) passes (one shared comparator,
//   registered bank reads), then ST_FETCH and one result word per cycle while
//   out_ready_i is high
// in_ready_o is low from the end of a batch until its last result is taken
// reset: asynchronous active-low; clears control, count and overflow flag
module stable_descending_merge_sorter_unit #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sort_key_i,
  input  logic        [15:0] item_handle_i,
  input  logic               batch_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_key_o,
  output logic        [15:0] out_handle_o,
  output logic               out_last_o,
  output logic               overflowed_o
);

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW   = mssu_pkg::KEY_BITS;
  // handles keep HANDLE_BITS bits, at most the bits that the port can carry
  localparam int unsigned HW   = (HANDLE_BITS < mssu_pkg::HANDLE_PORT) ?
                                 HANDLE_BITS : mssu_pkg::HANDLE_PORT;
  localparam int unsigned DW   = KW + HW;

  // one-hot top sequencer
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SORT  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_SHOW  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;   // loaded entries of the open batch
  logic [CNTW-1:0] n_q, n_d;       // entries of the batch being sorted/emitted
  logic [CNTW-1:0] emit_q, emit_d; // sorted position on the output
  logic ovf_q, ovf_d;
  logic fin_q, fin_d;              // bank holding the sorted batch

  logic in_acc, out_acc, load_we, room, mrg_start, last_word;
  logic [CNTW-1:0] n_load, emit_inc;
  mssu_pkg::mrg_ctl_t ctl;
  logic [AW-1:0] mrg_ra, mrg_rb, mrg_wa, emit_ra, ra, rb, b0_wa;
  logic [DW-1:0] b0_wd, b0_a, b0_b, b1_a, b1_b, src_a, src_b, mrg_wd, show_d;
  logic b0_we, b1_we;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_SHOW);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // store the word while there is room, else just remember the drop
  assign room      = (cnt_q < CNTW'(MAX_ENTRIES));
  assign load_we   = in_acc && room;
  assign n_load    = room ? (cnt_q + CNTW'(1)) : cnt_q;
  assign mrg_start = in_acc && batch_end_i;

  assign emit_inc  = emit_q + CNTW'(1);
  assign last_word = (emit_inc == n_q);

  // -- merge sequencer with the shared key comparator
  mssu_merge #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mrg_start),
    .n_i      (n_load),
    .key_a_i  (src_a[DW-1 -: KW]),
    .key_b_i  (src_b[DW-1 -: KW]),
    .raddr_a_o(mrg_ra),
    .raddr_b_o(mrg_rb),
    .waddr_o  (mrg_wa),
    .ctl_o    (ctl)
  );

  // -- read side: merge heads while sorting, output position otherwise
  // next position is addressed on the accepting edge so results stream back to back
  assign emit_ra = out_acc ? emit_inc[AW-1:0] : emit_q[AW-1:0];
  assign ra      = (state_q == ST_SORT) ? mrg_ra : emit_ra;
  assign rb      = (state_q == ST_SORT) ? mrg_rb : emit_ra;

  assign src_a  = ctl.src_bank ? b1_a : b0_a;
  assign src_b  = ctl.src_bank ? b1_b : b0_b;
  assign mrg_wd = ctl.take_b ? src_b : src_a;

  // -- write side: loading fills bank 0, merges ping-pong between banks
  assign b0_we = load_we || (ctl.wr_en && ctl.src_bank);
  assign b0_wa = load_we ? cnt_q[AW-1:0] : mrg_wa;
  assign b0_wd = load_we ? {sort_key_i, item_handle_i[HW-1:0]} : mrg_wd;
  assign b1_we = ctl.wr_en && !ctl.src_bank;

  mssu_mem #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(DW)
  ) u_bank0 (
    .clk_i    (clk_i),
    .we_i     (b0_we),
    .waddr_i  (b0_wa),
    .wdata_i  (b0_wd),
    .raddr_a_i(ra),
    .raddr_b_i(rb),
    .rdata_a_o(b0_a),
    .rdata_b_o(b0_b)
  );

  mssu_mem #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(DW)
  ) u_bank1 (
    .clk_i    (clk_i),
    .we_i     (b1_we),
    .waddr_i  (mrg_wa),
    .wdata_i  (mrg_wd),
    .raddr_a_i(ra),
    .raddr_b_i(rb),
    .rdata_a_o(b1_a),
    .rdata_b_o(b1_b)
  );

  // -- sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    emit_d  = emit_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          cnt_d = n_load;
          if (!room) begin
            ovf_d = 1'b1;
          end
          if (batch_end_i) begin
            n_d     = n_load;
            emit_d  = '0;
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
      end
      ST_FETCH: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_acc) begin
          emit_d = emit_inc;
          if (last_word) begin
            // batch done, open the next one
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
    // on done go fetch the sorted bank; single-entry batches finish on the loading edge itself
    if (ctl.done) begin
      fin_d   = ctl.fin_bank;
      state_d = ST_FETCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      emit_q  <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      emit_q  <= emit_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
    end
  end

  // -- result word straight from the registered bank read
  assign show_d       = fin_q ? b1_a : b0_a;
  assign out_key_o    = show_d[DW-1 -: KW];
  assign out_handle_o = mssu_pkg::HANDLE_PORT'(show_d[HW-1:0]);
  assign out_last_o   = last_word;
  assign overflowed_o = ovf_q;

endmodule

@@ test/tb_stable_descending_merge_sorter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_descending_merge_sorter_unit: self-checking bench of the sorter
// loads batches of keyed words, predicts the stable descending order with an
// insertion sort of its own, checks every sorted word field by field, covers
// ties, extreme keys, full and overflowing batches under random back-pressure
// ----------------------------------------------------------------------------

module tb_stable_descending_merge_sorter_unit;

  localparam int unsigned KEY_BITS     = mssu_pkg::KEY_BITS;
  localparam int unsigned HANDLE_PORT  = mssu_pkg::HANDLE_PORT;
  localparam int unsigned ENTRY_CAP    = 32;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned DRAIN_CYCLES = 64;   // covers the fetch and output pipe
  localparam int unsigned LONG_STALL   = 800;  // longer than a full 32-entry sort
  localparam int unsigned PHASE_WORDS  = 100;

  // --------------------------------------------------------------------------
  // scoreboard: keeps the open batch, sorts it when the flagged word is taken
  // and holds the sorted words that the block still owes
  // --------------------------------------------------------------------------
  class sort_scoreboard;
    typedef struct {
      logic signed [KEY_BITS-1:0]    key;
      logic        [HANDLE_PORT-1:0] handle;
      logic                          last;
      logic                          ovf;
    } sorted_word_t;

    int unsigned                   cap;
    logic        [HANDLE_PORT-1:0] handle_mask;
    logic signed [KEY_BITS-1:0]    open_keys[$];
    logic        [HANDLE_PORT-1:0] open_handles[$];
    bit                            open_dropped;
    sorted_word_t                  owed[$];
    int unsigned                   errors;
    int unsigned                   entries_in;
    int unsigned                   batches;
    int unsigned                   ovf_batches;
    int unsigned                   words_checked;

    function new(int unsigned capacity, int unsigned hbits);
      cap           = capacity;
      handle_mask   = (hbits >= HANDLE_PORT) ? '1 : HANDLE_PORT'((1 << hbits) - 1);
      open_dropped  = 1'b0;
      errors        = 0;
      entries_in    = 0;
      batches       = 0;
      ovf_batches   = 0;
      words_checked = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // note one accepted input word; on the flagged word the batch is sorted
    function void note_entry(logic signed [KEY_BITS-1:0] key,
                             logic [HANDLE_PORT-1:0] handle, logic batch_end);
      sorted_word_t ordered[$];
      sorted_word_t w;
      int unsigned  pos;
      entries_in++;
      if (open_keys.size() < cap) begin
        open_keys.push_back(key);
        open_handles.push_back(handle & handle_mask);
      end else begin
        open_dropped = 1'b1;
      end
      if (!batch_end) return;
      // stable insertion: a new word goes behind every word whose key is not less
      foreach (open_keys[i]) begin
        w.key    = open_keys[i];
        w.handle = open_handles[i];
        w.last   = 1'b0;
        w.ovf    = open_dropped;
        pos = 0;
        while (pos < ordered.size() && !(ordered[pos].key < w.key)) pos++;
        ordered.insert(pos, w);
      end
      ordered[ordered.size() - 1].last = 1'b1;
      foreach (ordered[i]) owed.push_back(ordered[i]);
      batches++;
      if (open_dropped) ovf_batches++;
      open_keys.delete();
      open_handles.delete();
      open_dropped = 1'b0;
    endfunction

    // compare one accepted output word with the oldest owed word
    function void check_result(logic signed [KEY_BITS-1:0] key,
                               logic [HANDLE_PORT-1:0] handle, logic last, logic ovf);
      sorted_word_t w;
      if (owed.size() == 0) begin
        $error("unexpected sorted word: key %0d handle %h", key, handle);
        errors++;
        return;
      end
      w = owed.pop_front();
      words_checked++;
      if (key !== w.key) begin
        $error("out_key: expected %0d, got %0d", w.key, key);
        errors++;
      end
      if (handle !== w.handle) begin
        $error("out_handle: expected %h, got %h", w.handle, handle);
        errors++;
      end
      if (last !== w.last) begin
        $error("out_last: expected %b, got %b", w.last, last);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $error("overflowed: expected %b, got %b", w.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic signed [KEY_BITS-1:0]    sort_key_i    = '0;
  logic        [HANDLE_PORT-1:0] item_handle_i = '0;
  logic                          batch_end_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic signed [KEY_BITS-1:0]    out_key_o;
  logic        [HANDLE_PORT-1:0] out_handle_o;
  logic                          out_last_o;
  logic                          overflowed_o;

  sort_scoreboard sb = new(ENTRY_CAP, HANDLE_W);

  int unsigned tx_idle_pct = 0;   // chance in percent that the sender skips a cycle
  int unsigned rx_idle_pct = 0;   // chance in percent that the receiver stalls
  int unsigned hold_req    = 0;   // long receiver stall asked by the stimulus
  int unsigned hold_left   = 0;   // cycles of that stall still to go
  int unsigned words_sent  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  stable_descending_merge_sorter_unit #(
    .MAX_ENTRIES(ENTRY_CAP),
    .HANDLE_BITS(HANDLE_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sort_key_i   (sort_key_i),
    .item_handle_i(item_handle_i),
    .batch_end_i  (batch_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_key_o    (out_key_o),
    .out_handle_o (out_handle_o),
    .out_last_o   (out_last_o),
    .overflowed_o (overflowed_o)
  );

  // --------------------------------------------------------------------------
  // receiver: random stalls, or one long stall counted here cycle by cycle
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // every accepted output word is checked at the edge that takes it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_key_o, out_handle_o, out_last_o, overflowed_o);
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  // offer one word; returns just after the edge that accepted it
  task automatic send_word(logic signed [KEY_BITS-1:0] key,
                           logic [HANDLE_PORT-1:0] handle, logic batch_end);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sort_key_i    <= key;
    item_handle_i <= handle;
    batch_end_i   <= batch_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_entry(key, handle, batch_end);
    words_sent++;
  endtask

  // stop offering and wait until every owed word has come back
  task automatic drain_all();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // keys lean toward a few small values so that ties are common
  function automatic logic signed [KEY_BITS-1:0] pick_key();
    logic signed [KEY_BITS-1:0] k;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: k = KEY_BITS'($urandom_range(6, 0)) - 3;
      4: begin
        case ($urandom_range(3, 0))
          0:       k = 32'sh8000_0000;
          1:       k = 32'sh7fff_ffff;
          2:       k = '0;
          default: k = '1;
        endcase
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // one batch of n words, the flag on the last; past ENTRY_CAP the block drops
  task automatic send_batch(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_word(pick_key(), HANDLE_PORT'($urandom()), i == n - 1);
  endtask

  // mostly short batches, some up to a full store, a few that overflow it
  task automatic random_phase(int unsigned first_size);
    int unsigned start;
    int unsigned r;
    start = words_sent;
    send_batch(first_size);
    while (words_sent - start < PHASE_WORDS) begin
      r = $urandom_range(99, 0);
      if (r < 65)      send_batch($urandom_range(6, 1));
      else if (r < 88) send_batch($urandom_range(ENTRY_CAP, 7));
      else             send_batch($urandom_range(ENTRY_CAP + 8, ENTRY_CAP + 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 37;
    rx_idle_pct = 60;

    // single word with the largest key and all handle bits set
    send_word(32'sh7fff_ffff, 16'hffff, 1'b1);
    // extreme keys: smallest, zero, minus one, largest
    send_word(32'sh8000_0000, 16'h0000, 1'b0);
    send_word(32'sh0000_0000, 16'h0001, 1'b0);
    send_word(-32'sd1,        16'h0002, 1'b0);
    send_word(32'sh7fff_ffff, 16'h0003, 1'b1);
    // ties between runs: equal keys must keep their load order
    send_word(32'sd5,  16'h0010, 1'b0);
    send_word(32'sd5,  16'h0011, 1'b0);
    send_word(-32'sd3, 16'h0012, 1'b0);
    send_word(32'sd5,  16'h0013, 1'b0);
    send_word(-32'sd3, 16'h0014, 1'b0);
    send_word(32'sd5,  16'h0015, 1'b1);
    // every key equal and the smallest
    send_word(32'sh8000_0000, 16'haaaa, 1'b0);
    send_word(32'sh8000_0000, 16'h5555, 1'b0);
    send_word(32'sh8000_0000, 16'h0000, 1'b1);
    // ascending input, fully reversed by the sort
    for (int i = 1; i <= 5; i++) send_word(KEY_BITS'(i), HANDLE_PORT'(16'h0100 + i), i == 5);
    // already descending
    send_word(32'sd9, 16'h0200, 1'b0);
    send_word(32'sd8, 16'h0201, 1'b0);
    send_word(32'sd7, 16'h0202, 1'b1);

    // first random phase opens with an exactly full store
    random_phase(ENTRY_CAP);
    drain_all();

    // second phase: a long receiver stall while the sender keeps offering,
    // opened by a batch whose flagged word is itself dropped
    tx_idle_pct = 60;
    rx_idle_pct = 37;
    hold_req    = LONG_STALL;
    random_phase(ENTRY_CAP + 1);
    drain_all();

    // last phase at full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(ENTRY_CAP + 5);
    drain_all();

    $display("sent %0d words in %0d batches, %0d of them over capacity",
             sb.entries_in, sb.batches, sb.ovf_batches);
    $display("checked %0d sorted words with ties, extreme keys and stalls on both sides",
             sb.words_checked);
    if (sb.errors == 0) begin
      $display("tb_stable_descending_merge_sorter_unit: clean");
    end else begin
      $display("tb_stable_descending_merge_sorter_unit: errors");
    end
    $finish;
  end

  // hard limit well above the slowest legal run
  initial begin
    #4ms;
    $display("tb_stable_descending_merge_sorter_unit: errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/mssu_pkg.sv
src/mssu_mem.sv
src/mssu_merge.sv
src/stable_descending_merge_sorter_unit.sv
test/tb_stable_descending_merge_sorter_unit.sv
